FILE: rtl/pfec_pkg.sv
// ----------------------------------------------------------------------------
// pfec_pkg
// shared constants, types and coding functions for the packet fec encoder
// ----------------------------------------------------------------------------
package pfec_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned GROUP_W     = 32;
   localparam int unsigned MAX_BYTES   = 12;
   localparam int unsigned BUF_W       = MAX_BYTES * BYTE_W;
   localparam int unsigned COUNT_W     = 4;
   localparam int unsigned HIST_W      = 3;

   localparam logic [15:0] CRC_POLY    = 16'h8005;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [7:0]  TERM_BYTE   = 8'h0B;

   localparam logic [COUNT_W-1:0] CNT_NONE  = 4'd0;
   localparam logic [COUNT_W-1:0] CNT_ONE   = 4'd1;
   localparam logic [COUNT_W-1:0] CNT_PAIR  = 4'd4;
   localparam logic [COUNT_W-1:0] CNT_TWO   = 4'd8;
   localparam logic [COUNT_W-1:0] CNT_THREE = 4'd12;

   // two-bit output symbol per 4-bit coder window
   localparam logic [1:0] SYM_TABLE [16] = '{
      2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1,
      2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2
   };

   // block of result bytes handed from the core to the output buffer
   typedef struct packed {
      logic                  valid;
      logic [COUNT_W-1:0]    count;
      logic                  last;
      logic [BUF_W-1:0]      bytes;
   } pfec_load_type;

   // crc-16, msb first, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i,
                                            input logic [7:0]  byte_i);
      logic [15:0] c;
      logic        fb;
      c = crc_i;
      for (int k = 0; k < 8; k++) begin
         fb = c[15] ^ byte_i[7-k];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // k=4 rate-1/2 convolutional code of one byte, first symbol in the top bits
   function automatic logic [15:0] conv_byte(input logic [HIST_W-1:0] hist_i,
                                             input logic [7:0]        byte_i);
      logic [10:0] r;
      logic [15:0] w;
      r = {hist_i, byte_i};
      w = '0;
      for (int k = 0; k < 8; k++) begin
         w[15-2*k -: 2] = SYM_TABLE[r[10-k -: 4]];
      end
      return w;
   endfunction

   // 4x4 two-bit-symbol interleave of a word pair
   function automatic logic [31:0] interleave(input logic [15:0] w0_i,
                                              input logic [15:0] w1_i);
      logic [7:0]  f [4];
      logic [31:0] acc;
      f[0] = w0_i[15:8];
      f[1] = w0_i[7:0];
      f[2] = w1_i[15:8];
      f[3] = w1_i[7:0];
      acc  = '0;
      for (int j = 0; j < 16; j++) begin
         acc[31-2*j -: 2] = f[3-(j & 3)][2*(j >> 2) +: 2];
      end
      return acc;
   endfunction

endpackage

FILE: rtl/packet_fec_encoder.sv
// path: the result bytes of a request, if it has any, pass through the input
// register and then the result buffer before they are on the result port
// throughput: 1 request per cycle into the input register unless the core
// waits on the result buffer; the byte-wide result buffer bounds the rate
// (4 bytes per pair of packet bytes, 8 or 12 bytes for the last request)
// reset: synchronous, active high; crc back to all ones, coder and pair state
// cleared, input register and result buffer emptied
// ----------------------------------------------------------------------------
// packet_fec_encoder
// crc-16 append, k=4 rate-1/2 convolutional coder and 4x4 interleaver
// ----------------------------------------------------------------------------
module packet_fec_encoder
   import pfec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_in
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast    // last_out
);

   // block of up to twelve coded bytes from one request
   pfec_load_type load;
   logic          load_ready;

   // input register, running crc, coder history and the held word of a pair;
   // a first-of-pair request only updates state and needs no buffer space
   pfec_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .load_ready (load_ready),
      .load       (load)
   );

   // output side: buffer refilled as its final byte is taken, so the
   // result channel streams without gaps while requests keep coming
   pfec_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/pfec_core.sv
// ----------------------------------------------------------------------------
// pfec_core
// input register, crc and coder state, and one-pass build of result bytes
// ----------------------------------------------------------------------------
module pfec_core
   import pfec_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                load_ready,
   output pfec_load_type       load
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_data_ff;
   logic                in_last_ff;

   logic [15:0]         crc_ff, crc_in;
   logic [HIST_W-1:0]   hist_ff, hist_in;
   logic [WORD_W-1:0]   held_ff, held_in;
   logic                phase_ff, phase_in;

   logic [15:0]         crc_next;
   logic [WORD_W-1:0]   w_data, w_hi, w_lo, w_term, w_term2;
   logic [GROUP_W-1:0]  g_held_data, g_data_hi, g_hi_lo, g_lo_term, g_term_term;
   logic [COUNT_W-1:0]  count;
   logic                consume;

   // coded words for the byte and, on a last byte, the packet trailer
   always_comb begin
      crc_next    = crc_byte(crc_ff, in_data_ff);
      w_data      = conv_byte(hist_ff, in_data_ff);
      w_hi        = conv_byte(in_data_ff[2:0], crc_next[15:8]);
      w_lo        = conv_byte(crc_next[10:8], crc_next[7:0]);
      w_term      = conv_byte(crc_next[2:0], TERM_BYTE);
      w_term2     = conv_byte(TERM_BYTE[2:0], TERM_BYTE);
      g_held_data = interleave(held_ff, w_data);
      g_data_hi   = interleave(w_data, w_hi);
      g_hi_lo     = interleave(w_hi, w_lo);
      g_lo_term   = interleave(w_lo, w_term);
      g_term_term = interleave(w_term, w_term2);
   end

   always_comb begin
      load.last  = in_last_ff;
      load.bytes = '0;
      if (!in_last_ff) begin
         count = phase_ff ? CNT_PAIR : CNT_NONE;
         load.bytes[BUF_W-1 -: GROUP_W] = g_held_data;
      end else if (phase_ff) begin
         count = CNT_THREE;
         load.bytes = {g_held_data, g_hi_lo, g_term_term};
      end else begin
         count = CNT_TWO;
         load.bytes[BUF_W-1 -: 2*GROUP_W] = {g_data_hi, g_lo_term};
      end
      load.count = count;
      load.valid = in_valid_ff && load_ready && (count != CNT_NONE);
   end

   // items with no result bytes never wait on the output buffer
   assign consume    = in_valid_ff && ((count == CNT_NONE) || load_ready);
   assign req_tready = !in_valid_ff || consume;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_comb begin
      crc_in   = crc_ff;
      hist_in  = hist_ff;
      held_in  = held_ff;
      phase_in = phase_ff;
      if (consume) begin
         if (in_last_ff) begin
            crc_in   = CRC_INIT;
            hist_in  = '0;
            held_in  = '0;
            phase_in = 1'b0;
         end else begin
            crc_in   = crc_next;
            hist_in  = in_data_ff[2:0];
            held_in  = phase_ff ? '0 : w_data;
            phase_in = !phase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         crc_ff      <= CRC_INIT;
         hist_ff     <= '0;
         held_ff     <= '0;
         phase_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         crc_ff      <= crc_in;
         hist_ff     <= hist_in;
         held_ff     <= held_in;
         phase_ff    <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

endmodule

FILE: rtl/pfec_outbuf.sv
// ----------------------------------------------------------------------------
// pfec_outbuf
// result byte buffer, drained one byte per cycle when rsp_tready is high
// ----------------------------------------------------------------------------
module pfec_outbuf
   import pfec_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  pfec_load_type       load,
   output logic                load_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);

   logic [BUF_W-1:0]    buf_ff, buf_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic                last_ff, last_in;
   logic                take;

   assign rsp_tvalid = (cnt_ff != CNT_NONE);
   assign rsp_tdata  = buf_ff[BUF_W-1 -: BYTE_W];
   assign rsp_tlast  = last_ff && (cnt_ff == CNT_ONE);
   assign take       = rsp_tvalid && rsp_tready;
   // refill in the same cycle the final byte leaves
   assign load_ready = (cnt_ff == CNT_NONE) || ((cnt_ff == CNT_ONE) && rsp_tready);

   always_comb begin
      buf_in  = buf_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      if (load.valid) begin
         buf_in  = load.bytes;
         cnt_in  = load.count;
         last_in = load.last;
      end else if (take) begin
         buf_in  = {buf_ff[BUF_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
         cnt_in  = cnt_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= CNT_NONE;
         last_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

FILE: rtl/pfec_checker.sv
// ----------------------------------------------------------------------------
// pfec_checker
// port-level checks for the packet fec encoder, bound to the top level
// ----------------------------------------------------------------------------
module pfec_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast
);

   logic [1:0] phase_ff;

   // position of the next result byte inside its interleaved group
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         phase_ff <= phase_ff + 2'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   a_last_group: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> phase_ff == 2'd3)
      else $error("packet does not end on a whole group");

   // an empty result buffer never holds off a request
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result buffer");

endmodule

bind packet_fec_encoder pfec_checker u_pfec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
